/* hdl/swt_pkg.sv */
// Shared types, codes and default sizes for the segment window translator.
package swt_pkg;

  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int POS_BITS_DEF     = 48;
  localparam int ID_BITS_DEF      = 16;

  // Fixed widths of the fields on the ports.
  localparam int ITEM_POS_W = 48;
  localparam int ITEM_ID_W  = 16;

  typedef enum logic [1:0] {
    ACT_START,
    ACT_APPEND,
    ACT_UNHASH,
    ACT_HASH
  } action_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_WINDOW,
    ST_POS_RANGE,
    ST_ABSENT,
    ST_LOCAL_RANGE,
    ST_FULL,
    ST_OVERFLOW
  } status_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_UNHASH,
    S_UNHASH_SUB,
    S_SCAN_HASH,
    S_HASH_CMP
  } fsm_state_t;

  typedef struct packed {
    action_t                 action;
    logic [ITEM_ID_W-1:0]    segment_id;
    logic [ITEM_POS_W-1:0]   segment_size;
    logic [ITEM_POS_W-1:0]   window_position_in;
    logic [ITEM_POS_W-1:0]   local_position_in;
  } item_t;

  typedef struct packed {
    logic [ITEM_POS_W-1:0]   window_position_out;
    logic [ITEM_ID_W-1:0]    segment_id_out;
    logic [ITEM_POS_W-1:0]   local_position_out;
    logic [ITEM_POS_W-1:0]   total_positions;
    logic                    window_loops;
    status_t                 status;
  } result_t;

endpackage

/* hdl/swt_alu.sv */
// Shared add and subtract unit used for every offset sum and compare.
module swt_alu #(
  parameter int POS_BITS = swt_pkg::POS_BITS_DEF
) (
  input  swt_pkg::alu_op_t    op,
  input  logic [POS_BITS:0]   a,
  input  logic [POS_BITS:0]   b,
  output logic [POS_BITS+1:0] res
);

  // On a subtraction the top bit is the borrow, so it reads as a < b.
  always_comb begin
    case (op)
      swt_pkg::ALU_ADD: res = {1'b0, a} + {1'b0, b};
      swt_pkg::ALU_SUB: res = {1'b0, a} - {1'b0, b};
      default:          res = '0;
    endcase
  end

endmodule

/* hdl/segment_window_translator_top.sv */
// Segment window table with a sequencer for start, append, unhash and hash commands.
// Start, append and an unhash out of range finish in the dispatch state; done is registered.
// An unhash or hash scans from entry 0 to its hit, then finishes in a subtract or compare state;
// a hash miss scans all filled entries, one entry per cycle through the single read port.
// busy is high from the transfer until done, and results cannot be stalled.
// Reset empties the window; the table contents are not cleared and are never read unwritten.
module segment_window_translator_top #(
  parameter int MAX_SEGMENTS = swt_pkg::MAX_SEGMENTS_DEF,
  parameter int POS_BITS     = swt_pkg::POS_BITS_DEF,
  parameter int ID_BITS      = swt_pkg::ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  swt_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output swt_pkg::result_t result
);

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int OW  = swt_pkg::ITEM_POS_W;
  localparam int OIW = swt_pkg::ITEM_ID_W;
  localparam logic [CW-1:0]       MAX_CNT = CW'(MAX_SEGMENTS);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  swt_pkg::fsm_state_t state, state_next;
  swt_pkg::item_t      cmd;

  logic [CW-1:0]       count, count_next;
  logic                loop, loop_next;
  logic                ready, ready_next;
  logic [ID_BITS-1:0]  own_id, own_id_next;
  logic [POS_BITS-1:0] total, total_next;
  logic [POS_BITS-1:0] base, base_next;
  logic [CW-1:0]       idx, idx_next;
  logic [ID_BITS-1:0]  hit_id, hit_id_next;
  logic [POS_BITS-1:0] hit_end, hit_end_next;
  logic [POS_BITS:0]   sum_reg, sum_next;
  swt_pkg::result_t    result_next;
  logic                done_next;

  // Window table.
  logic [ID_BITS-1:0]  ids  [MAX_SEGMENTS];
  logic [POS_BITS-1:0] ends [MAX_SEGMENTS];
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [ID_BITS-1:0]  wr_id;
  logic [POS_BITS-1:0] wr_end;
  logic [IW-1:0]       rd_addr;
  logic [ID_BITS-1:0]  rd_id;
  logic [POS_BITS-1:0] rd_end;

  swt_pkg::alu_op_t    alu_op;
  logic [POS_BITS:0]   alu_a, alu_b;
  logic [POS_BITS+1:0] alu_res;

  logic                finish;
  swt_pkg::status_t    res_st;
  logic [POS_BITS-1:0] res_w, res_l;
  logic [ID_BITS-1:0]  res_id;

  logic [ID_BITS-1:0]  c_id;
  logic [POS_BITS-1:0] c_size, c_wpos, c_lpos;

  assign c_id   = ID_BITS'(cmd.segment_id);
  assign c_size = POS_BITS'(cmd.segment_size);
  assign c_wpos = POS_BITS'(cmd.window_position_in);
  assign c_lpos = POS_BITS'(cmd.local_position_in);

  assign busy = (state != swt_pkg::S_IDLE);

  swt_alu #(.POS_BITS(POS_BITS)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    loop_next    = loop;
    ready_next   = ready;
    own_id_next  = own_id;
    total_next   = total;
    base_next    = base;
    idx_next     = idx;
    hit_id_next  = hit_id;
    hit_end_next = hit_end;
    sum_next     = sum_reg;
    wr_en        = 1'b0;
    wr_addr      = count[IW-1:0];
    wr_id        = c_id;
    wr_end       = '0;
    alu_op       = swt_pkg::ALU_SUB;
    alu_a        = {1'b0, c_wpos};
    alu_b        = {1'b0, total};
    finish       = 1'b0;
    res_st       = swt_pkg::ST_OK;
    res_w        = '0;
    res_l        = '0;
    res_id       = '0;

    case (state)
      swt_pkg::S_IDLE: begin
        if (start) begin
          state_next = swt_pkg::S_DISPATCH;
        end
      end
      swt_pkg::S_DISPATCH: begin
        if (cmd.action == swt_pkg::ACT_START) begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          wr_end      = c_size;
          own_id_next = c_id;
          total_next  = c_size;
          count_next  = CW'(1);
          loop_next   = 1'b0;
          ready_next  = 1'b1;
          finish      = 1'b1;
        end else if (!ready) begin
          res_st = swt_pkg::ST_NO_WINDOW;
          finish = 1'b1;
        end else begin
          case (cmd.action)
            swt_pkg::ACT_APPEND: begin
              finish = 1'b1;
              if (c_id == own_id) begin
                loop_next = 1'b1;
              end else if (count == MAX_CNT) begin
                res_st = swt_pkg::ST_FULL;
              end else begin
                alu_op = swt_pkg::ALU_ADD;
                alu_a  = {1'b0, total};
                alu_b  = {1'b0, c_size};
                if (alu_res[POS_BITS]) begin
                  wr_end = POS_MAX;
                  res_st = swt_pkg::ST_OVERFLOW;
                end else begin
                  wr_end = alu_res[POS_BITS-1:0];
                end
                wr_en      = 1'b1;
                total_next = wr_end;
                count_next = count + CW'(1);
              end
            end
            swt_pkg::ACT_UNHASH: begin
              // The position must lie below the end of the last segment.
              if (!alu_res[POS_BITS+1]) begin
                res_st = swt_pkg::ST_POS_RANGE;
                finish = 1'b1;
              end else begin
                idx_next   = '0;
                base_next  = '0;
                state_next = swt_pkg::S_SCAN_UNHASH;
              end
            end
            default: begin
              idx_next   = '0;
              base_next  = '0;
              state_next = swt_pkg::S_SCAN_HASH;
            end
          endcase
        end
      end
      swt_pkg::S_SCAN_UNHASH: begin
        alu_b = {1'b0, rd_end};
        if (alu_res[POS_BITS+1]) begin
          hit_id_next = rd_id;
          state_next  = swt_pkg::S_UNHASH_SUB;
        end else begin
          base_next = rd_end;
          idx_next  = idx + CW'(1);
        end
      end
      swt_pkg::S_UNHASH_SUB: begin
        alu_b  = {1'b0, base};
        res_id = hit_id;
        res_l  = alu_res[POS_BITS-1:0];
        finish = 1'b1;
      end
      swt_pkg::S_SCAN_HASH: begin
        if (idx == count) begin
          res_st = swt_pkg::ST_ABSENT;
          finish = 1'b1;
        end else if (rd_id == c_id) begin
          alu_op       = swt_pkg::ALU_ADD;
          alu_a        = {1'b0, base};
          alu_b        = {1'b0, c_lpos};
          sum_next     = alu_res[POS_BITS:0];
          hit_end_next = rd_end;
          state_next   = swt_pkg::S_HASH_CMP;
        end else begin
          base_next = rd_end;
          idx_next  = idx + CW'(1);
        end
      end
      swt_pkg::S_HASH_CMP: begin
        // base + local below the segment end is the same as local below the size.
        alu_a  = sum_reg;
        alu_b  = {1'b0, hit_end};
        finish = 1'b1;
        if (alu_res[POS_BITS+1]) begin
          res_w = sum_reg[POS_BITS-1:0];
        end else begin
          res_st = swt_pkg::ST_LOCAL_RANGE;
        end
      end
      default: begin
        state_next = swt_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = swt_pkg::S_IDLE;
    end

    rd_addr   = idx_next[IW-1:0];
    done_next = finish;

    result_next.window_position_out = OW'(res_w);
    result_next.segment_id_out      = OIW'(res_id);
    result_next.local_position_out  = OW'(res_l);
    result_next.total_positions     = ready_next ? OW'(total_next) : '0;
    result_next.window_loops        = loop_next;
    result_next.status              = res_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swt_pkg::S_IDLE;
      count <= '0;
      loop  <= 1'b0;
      ready <= 1'b0;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      loop  <= loop_next;
      ready <= ready_next;
      done  <= done_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= item;
    end
    own_id  <= own_id_next;
    total   <= total_next;
    base    <= base_next;
    hit_id  <= hit_id_next;
    hit_end <= hit_end_next;
    sum_reg <= sum_next;
    result  <= result_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]  <= wr_id;
      ends[wr_addr] <= wr_end;
    end
    rd_id  <= ids[rd_addr];
    rd_end <= ends[rd_addr];
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while a command is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not make the block busy");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("entry count beyond table depth");

  a_no_window: assert property (@(posedge clk) disable iff (rst)
    !ready |-> (count == '0))
    else $error("table holds entries without a window");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == swt_pkg::S_SCAN_HASH) |-> (idx <= count))
    else $error("hash scan ran past the filled entries");

endmodule
